// ===== hw/rtl/ppfl_pkg.sv =====
// Shared types and constants of the page pool free list allocator.
`timescale 1ns / 1ps
`default_nettype none

package ppfl_pkg;

	// Pool geometry
	localparam int MAX_PAGES = 1024;
	localparam int PAGE_W    = $clog2(MAX_PAGES);
	localparam int CNT_W     = PAGE_W + 1;

	// Field widths
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 3;
	localparam int USER_W   = 32;
	localparam int ESIZE_W  = 16;
	localparam int ECOUNT_W = 24;
	localparam int PSIZE_W  = 25;
	localparam int OFFS_W   = 34;
	localparam int BYTES_W  = ESIZE_W + ECOUNT_W;
	localparam int DESC_W   = USER_W + BYTES_W + ECOUNT_W;
	localparam int CFG_IDX_W = 2;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INIT   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FREE   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_EXPAND = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_RESIZE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EXCEEDS   = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAGES    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_RESIZE = 2'd3;

	// Datapath operation for the current cycle
	typedef enum logic [2:0] {
		DP_NONE,
		DP_ACCEPT,
		DP_EXEC,
		DP_SWEEP,
		DP_PUSH,
		DP_FINISH
	} dp_op_t;

	// Controller to datapath
	typedef struct packed {
		dp_op_t op;
		logic   init_fill;
	} dp_ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             out_free;
		logic             walk;
		logic             sweep_last;
		logic             push_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/page_pool_free_list_allocator.sv =====
// Top level of the page pool free list allocator.
//
// Commands enter on the in_valid/in_ready channel, one transfer per command,
// and each gives exactly one result transfer on out_valid/out_ready.
// Configuration registers are written over cfg_valid/cfg_ready (always ready).
// The user must write them only while no command is in flight; the block does
// not enforce this. For allocate, free, query, refused expand, zero-page expand
// and unknown codes, the input transfer launches the stack, mark and descriptor
// memory reads; in S_EXEC, once the result register is free, the pool is
// updated and the result loaded.
// Init walks every page once (clearing marks, filling the stack).
// An expand that adds pages pushes one per cycle.
// Only one command is worked on at a time; the next input transfer is taken
// as soon as the previous result is loaded, even if it is not yet taken.
// A stalled receiver holds the result register; a finished command then waits
// before loading until the register frees up.
// After reset the mark memory is cleared in a pass over every page with
// in_ready low; the pool is empty until an init command.
`timescale 1ns / 1ps
`default_nettype none

module page_pool_free_list_allocator
	import ppfl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// command channel
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [CMD_W-1:0]     command,
	input  wire logic [PAGE_W-1:0]    page_id,
	input  wire logic [USER_W-1:0]    user_id,
	input  wire logic [ESIZE_W-1:0]   elem_size,
	input  wire logic [ECOUNT_W-1:0]  elem_count,
	input  wire logic [CNT_W-1:0]     extra_pages,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [STATUS_W-1:0]  status,
	output logic      [PAGE_W-1:0]    result_page,
	output logic      [OFFS_W-1:0]    byte_offset,
	output logic      [USER_W-1:0]    owner_id,
	output logic      [BYTES_W-1:0]   bytes_used,
	output logic      [ECOUNT_W-1:0]  stored_count,
	output logic      [CNT_W-1:0]     free_count,
	output logic      [CNT_W-1:0]     total_pages,
	// configuration channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [PSIZE_W-1:0]   cfg_data
);

	dp_ctl_t  ctl;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	// Sequencer
	ppfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// Memories, counters and result register
	ppfl_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.command       (command),
		.page_id       (page_id),
		.user_id       (user_id),
		.elem_size     (elem_size),
		.elem_count    (elem_count),
		.extra_pages   (extra_pages),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.result_page   (result_page),
		.byte_offset   (byte_offset),
		.owner_id      (owner_id),
		.bytes_used    (bytes_used),
		.stored_count  (stored_count),
		.free_count    (free_count),
		.total_pages   (total_pages)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/ppfl_ram.sv =====
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module ppfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ppfl_ctrl.sv =====
// Controller state machine of the page pool free list allocator.
`timescale 1ns / 1ps
`default_nettype none

module ppfl_ctrl
	import ppfl_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire dp_stat_t stat,
	output dp_ctl_t       ctl
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_INIT,
		S_PUSH,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and datapath command
	always_comb begin
		state_d       = state_q;
		ctl.op        = DP_NONE;
		ctl.init_fill = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ctl.op = DP_SWEEP;
				if (stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					ctl.op  = DP_ACCEPT;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.cmd == CMD_INIT) begin
					state_d = S_INIT;
				end else if (stat.walk) begin
					ctl.op  = DP_EXEC;
					state_d = S_PUSH;
				end else if (stat.out_free) begin
					ctl.op  = DP_EXEC;
					state_d = S_IDLE;
				end
			end
			S_INIT: begin
				ctl.op        = DP_SWEEP;
				ctl.init_fill = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_DONE;
				end
			end
			S_PUSH: begin
				ctl.op = DP_PUSH;
				if (stat.push_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					ctl.op  = DP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register; reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ppfl_dp.sv =====
// Datapath: configuration, free stack, in-use marks, descriptors and result register.
`timescale 1ns / 1ps
`default_nettype none

module ppfl_dp
	import ppfl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dp_ctl_t               ctl,
	output dp_stat_t                   stat,
	// input item
	input  wire logic [CMD_W-1:0]      command,
	input  wire logic [PAGE_W-1:0]     page_id,
	input  wire logic [USER_W-1:0]     user_id,
	input  wire logic [ESIZE_W-1:0]    elem_size,
	input  wire logic [ECOUNT_W-1:0]   elem_count,
	input  wire logic [CNT_W-1:0]      extra_pages,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [PSIZE_W-1:0]    cfg_data,
	// result item
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [STATUS_W-1:0]   status,
	output logic      [PAGE_W-1:0]     result_page,
	output logic      [OFFS_W-1:0]     byte_offset,
	output logic      [USER_W-1:0]     owner_id,
	output logic      [BYTES_W-1:0]    bytes_used,
	output logic      [ECOUNT_W-1:0]   stored_count,
	output logic      [CNT_W-1:0]      free_count,
	output logic      [CNT_W-1:0]      total_pages
);

	// Configuration registers
	logic [PSIZE_W-1:0] page_size_q;
	logic [CNT_W-1:0]   initial_q;
	logic [CNT_W-1:0]   max_pages_q;
	logic               allow_q;

	// Latched item
	logic [CMD_W-1:0]    cmd_q;
	logic [PAGE_W-1:0]   page_id_q;
	logic [USER_W-1:0]   user_q;
	logic [ESIZE_W-1:0]  esize_q;
	logic [ECOUNT_W-1:0] ecount_q;
	logic [CNT_W-1:0]    extra_q;
	logic [CNT_W-1:0]    fill_n_q;

	// Pool state and walk counters
	logic [CNT_W-1:0] depth_q;
	logic [CNT_W-1:0] pool_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] total_q;
	logic             out_valid_q;

	// Memory ports
	logic                stk_we, stk_re, use_we, use_re, use_wdata, use_rdata;
	logic                desc_we, desc_re;
	logic [PAGE_W-1:0]   stk_waddr, stk_wdata, stk_raddr, stk_rdata;
	logic [PAGE_W-1:0]   use_waddr, use_raddr, desc_waddr, desc_raddr;
	logic [DESC_W-1:0]   desc_wdata, desc_rdata;

	// Working values
	logic                accept, load_out, sweep_fill;
	logic [CNT_W:0]      exp_total;
	logic                exp_ok;
	logic [BYTES_W-1:0]  used_prod;
	logic [PAGE_W-1:0]   off_page;
	logic [PSIZE_W+PAGE_W-1:0] off_prod;
	logic [STATUS_W-1:0] o_status;
	logic [PAGE_W-1:0]   o_page;
	logic                o_has_page;
	logic [USER_W-1:0]   o_owner;
	logic [BYTES_W-1:0]  o_bytes;
	logic [ECOUNT_W-1:0] o_count;
	logic [CNT_W-1:0]    depth_d;

	assign accept     = (ctl.op == DP_ACCEPT);
	assign sweep_fill = ctl.init_fill && (idx_q < fill_n_q);

	// Expand checks
	assign exp_total = (CNT_W+1)'(pool_q) + (CNT_W+1)'(extra_q);
	assign exp_ok    = allow_q && (exp_total <= (CNT_W+1)'(max_pages_q))
		&& (exp_total <= (CNT_W+1)'(MAX_PAGES));

	// Status to controller
	assign stat.cmd        = cmd_q;
	assign stat.out_free   = !out_valid_q || out_ready;
	assign stat.walk       = (cmd_q == CMD_EXPAND) && exp_ok && (extra_q != '0);
	assign stat.sweep_last = (idx_q == CNT_W'(MAX_PAGES - 1));
	assign stat.push_last  = ((idx_q + 1'b1) == total_q);

	assign load_out = ((ctl.op == DP_EXEC) && !stat.walk) || (ctl.op == DP_FINISH);

	// Multipliers feeding the result register and descriptor write
	assign used_prod = BYTES_W'(esize_q) * BYTES_W'(ecount_q);
	assign off_prod  = (PSIZE_W+PAGE_W)'(off_page) * (PSIZE_W+PAGE_W)'(page_size_q);

	// Memory reads are launched with the item transfer
	assign stk_re     = accept;
	assign stk_raddr  = PAGE_W'(depth_q - 1'b1);
	assign use_re     = accept;
	assign use_raddr  = page_id;
	assign desc_re    = accept;
	assign desc_raddr = page_id;

	// Command execution, sweep and push steps
	always_comb begin
		stk_we     = 1'b0;
		stk_waddr  = depth_q[PAGE_W-1:0];
		stk_wdata  = idx_q[PAGE_W-1:0];
		use_we     = 1'b0;
		use_waddr  = idx_q[PAGE_W-1:0];
		use_wdata  = 1'b0;
		desc_we    = 1'b0;
		desc_waddr = stk_rdata;
		desc_wdata = {user_q, used_prod, ecount_q};
		o_status   = ST_OK;
		o_page     = '0;
		o_has_page = 1'b0;
		o_owner    = '0;
		o_bytes    = '0;
		o_count    = '0;
		depth_d    = depth_q;
		off_page   = stk_rdata;
		unique case (ctl.op)
			DP_EXEC: begin
				unique case (cmd_q)
					CMD_ALLOC: begin
						if (depth_q == '0) begin
							o_status = ST_NO_FREE;
						end else begin
							depth_d    = depth_q - 1'b1;
							use_we     = 1'b1;
							use_waddr  = stk_rdata;
							use_wdata  = 1'b1;
							desc_we    = 1'b1;
							o_page     = stk_rdata;
							o_has_page = 1'b1;
							o_owner    = user_q;
							o_bytes    = used_prod;
							o_count    = ecount_q;
						end
					end
					CMD_FREE: begin
						if (!use_rdata) begin
							o_status = ST_INVALID;
						end else begin
							use_we    = 1'b1;
							use_waddr = page_id_q;
							stk_we    = 1'b1;
							stk_wdata = page_id_q;
							depth_d   = depth_q + 1'b1;
						end
					end
					CMD_EXPAND: begin
						if (!allow_q) begin
							o_status = ST_NO_RESIZE;
						end else if (!exp_ok) begin
							o_status = ST_EXCEEDS;
						end
					end
					CMD_QUERY: begin
						off_page = page_id_q;
						if (!use_rdata) begin
							o_status = ST_INVALID;
						end else begin
							o_page     = page_id_q;
							o_has_page = 1'b1;
							o_owner    = desc_rdata[DESC_W-1 -: USER_W];
							o_bytes    = desc_rdata[ECOUNT_W +: BYTES_W];
							o_count    = desc_rdata[ECOUNT_W-1:0];
						end
					end
					default: begin
					end
				endcase
			end
			DP_SWEEP: begin
				use_we    = 1'b1;
				stk_we    = sweep_fill;
				stk_waddr = idx_q[PAGE_W-1:0];
			end
			DP_PUSH: begin
				stk_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= PSIZE_W'(65536);
			initial_q   <= CNT_W'(64);
			max_pages_q <= CNT_W'(512);
			allow_q     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAGE_SIZE:    page_size_q <= cfg_data;
				CFG_INITIAL:      initial_q   <= cfg_data[CNT_W-1:0];
				CFG_MAX_PAGES:    max_pages_q <= cfg_data[CNT_W-1:0];
				CFG_ALLOW_RESIZE: allow_q     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Item latch; init page count saturates at the pool size
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= command;
			page_id_q <= page_id;
			user_q    <= user_id;
			esize_q   <= elem_size;
			ecount_q  <= elem_count;
			extra_q   <= extra_pages;
			fill_n_q  <= (initial_q > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : initial_q;
		end
		if ((ctl.op == DP_EXEC) && stat.walk) begin
			total_q <= exp_total[CNT_W-1:0];
		end
	end

	// Stack depth, pool size and walk index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			pool_q  <= '0;
			idx_q   <= '0;
		end else begin
			unique case (ctl.op)
				DP_EXEC: begin
					depth_q <= depth_d;
					if (stat.walk) begin
						idx_q <= pool_q;
					end
				end
				DP_SWEEP: begin
					if (stat.sweep_last) begin
						idx_q <= '0;
						if (ctl.init_fill) begin
							depth_q <= fill_n_q;
							pool_q  <= fill_n_q;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				DP_PUSH: begin
					depth_q <= depth_q + 1'b1;
					if (stat.push_last) begin
						idx_q  <= '0;
						pool_q <= total_q;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			status       <= o_status;
			result_page  <= o_page;
			byte_offset  <= o_has_page ? off_prod[OFFS_W-1:0] : '0;
			owner_id     <= o_owner;
			bytes_used   <= o_bytes;
			stored_count <= o_count;
			free_count   <= depth_d;
			total_pages  <= pool_q;
		end
	end

	assign out_valid = out_valid_q;

	// Free stack
	ppfl_ram #(
		.WIDTH (PAGE_W),
		.DEPTH (MAX_PAGES)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// In-use marks
	ppfl_ram #(
		.WIDTH (1),
		.DEPTH (MAX_PAGES)
	) u_use_ram (
		.clk   (clk),
		.we    (use_we),
		.waddr (use_waddr),
		.wdata (use_wdata),
		.re    (use_re),
		.raddr (use_raddr),
		.rdata (use_rdata)
	);

	// Page descriptors: owner, used bytes, element count
	ppfl_ram #(
		.WIDTH (DESC_W),
		.DEPTH (MAX_PAGES)
	) u_desc_ram (
		.clk   (clk),
		.we    (desc_we),
		.waddr (desc_waddr),
		.wdata (desc_wdata),
		.re    (desc_re),
		.raddr (desc_raddr),
		.rdata (desc_rdata)
	);

endmodule

`default_nettype wire

// ===== bench/tb_page_pool_free_list_allocator.sv =====
// Self-checking testbench for the page pool free list allocator.
`timescale 1ns / 1ps

module tb_page_pool_free_list_allocator;
	import ppfl_pkg::*;

	localparam int LIVE = 0;           // copy that follows accepted commands
	localparam int PLAN = 1;           // copy that follows generated commands
	localparam int QUIET_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [PAGE_W-1:0]   page;
		logic [USER_W-1:0]   user;
		logic [ESIZE_W-1:0]  esize;
		logic [ECOUNT_W-1:0] ecount;
		logic [CNT_W-1:0]    extra;
	} pool_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PAGE_W-1:0]   page;
		logic [OFFS_W-1:0]   offset;
		logic [USER_W-1:0]   owner;
		logic [BYTES_W-1:0]  bytes;
		logic [ECOUNT_W-1:0] count;
		logic [CNT_W-1:0]    free_cnt;
		logic [CNT_W-1:0]    total;
	} pool_res_t;

	// DUT connections
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [CMD_W-1:0]     command = '0;
	logic [PAGE_W-1:0]    page_id = '0;
	logic [USER_W-1:0]    user_id = '0;
	logic [ESIZE_W-1:0]   elem_size = '0;
	logic [ECOUNT_W-1:0]  elem_count = '0;
	logic [CNT_W-1:0]     extra_pages = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [PAGE_W-1:0]    result_page;
	logic [OFFS_W-1:0]    byte_offset;
	logic [USER_W-1:0]    owner_id;
	logic [BYTES_W-1:0]   bytes_used;
	logic [ECOUNT_W-1:0]  stored_count;
	logic [CNT_W-1:0]     free_count;
	logic [CNT_W-1:0]     total_pages;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PSIZE_W-1:0]   cfg_data = '0;

	// Pool state, two copies
	logic [PAGE_W-1:0]   free_stk  [2][MAX_PAGES];
	bit                  in_use    [2][MAX_PAGES];
	logic [USER_W-1:0]   owner_mem [2][MAX_PAGES];
	logic [BYTES_W-1:0]  bytes_mem [2][MAX_PAGES];
	logic [ECOUNT_W-1:0] count_mem [2][MAX_PAGES];
	int unsigned depth [2] = '{0, 0};
	int unsigned pages [2] = '{0, 0};

	// Register copies, reset values
	int unsigned pg_size    [2] = '{65536, 65536};
	int unsigned init_pages [2] = '{64, 64};
	int unsigned max_pg     [2] = '{512, 512};
	bit          resize_ok  [2] = '{1'b1, 1'b1};

	pool_cmd_t   queued_cmds[$];
	pool_res_t   replies_due[$];
	pool_cmd_t   cur_cmd;
	bit          idle_on = 1'b1;
	int unsigned send_gap = 0;
	int unsigned recv_stall = 0;
	int unsigned quiet = 0;
	int          mismatches = 0;
	int          replies = 0;
	int          planned = 0;
	int          cfg_sets = 0;
	int          cmd_seen [8] = '{default: 0};
	int          status_seen [8] = '{default: 0};

	page_pool_free_list_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .page_id(page_id), .user_id(user_id),
		.elem_size(elem_size), .elem_count(elem_count),
		.extra_pages(extra_pages),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .result_page(result_page), .byte_offset(byte_offset),
		.owner_id(owner_id), .bytes_used(bytes_used), .stored_count(stored_count),
		.free_count(free_count), .total_pages(total_pages),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- prediction

	function automatic void push_free(input int c, input int unsigned pg);
		if (depth[c] < MAX_PAGES) begin
			free_stk[c][depth[c]] = PAGE_W'(pg);
			depth[c]++;
		end
	endfunction

	function automatic void describe(input int c, input int unsigned pg, inout pool_res_t r);
		r.page   = PAGE_W'(pg);
		r.offset = OFFS_W'(64'(pg) * 64'(pg_size[c]));
		r.owner  = owner_mem[c][pg];
		r.bytes  = bytes_mem[c][pg];
		r.count  = count_mem[c][pg];
	endfunction

	// Applies one command to copy c and returns the reply it yields
	function automatic pool_res_t pool_apply(input int c, input pool_cmd_t t);
		pool_res_t   r;
		int unsigned n, tot, pg, i;
		r = '0;
		unique case (t.cmd)
			CMD_INIT: begin
				n = (init_pages[c] > MAX_PAGES) ? MAX_PAGES : init_pages[c];
				for (i = 0; i < MAX_PAGES; i++) in_use[c][i] = 1'b0;
				depth[c] = 0;
				for (i = 0; i < n; i++) push_free(c, i);
				pages[c] = n;
			end
			CMD_ALLOC: begin
				if (depth[c] == 0) begin
					r.status = ST_NO_FREE;
				end else begin
					depth[c]--;
					pg = free_stk[c][depth[c]];
					in_use[c][pg]    = 1'b1;
					owner_mem[c][pg] = t.user;
					bytes_mem[c][pg] = BYTES_W'(64'(t.esize) * 64'(t.ecount));
					count_mem[c][pg] = t.ecount;
					describe(c, pg, r);
				end
			end
			CMD_FREE: begin
				if (!in_use[c][t.page]) begin
					r.status = ST_INVALID;
				end else begin
					in_use[c][t.page] = 1'b0;
					push_free(c, t.page);
				end
			end
			CMD_EXPAND: begin
				tot = pages[c] + t.extra;
				if (!resize_ok[c]) begin
					r.status = ST_NO_RESIZE;
				end else if (tot > max_pg[c] || tot > MAX_PAGES) begin
					r.status = ST_EXCEEDS;
				end else begin
					for (i = pages[c]; i < tot; i++) push_free(c, i);
					pages[c] = tot;
				end
			end
			CMD_QUERY: begin
				if (!in_use[c][t.page]) begin
					r.status = ST_INVALID;
				end else begin
					describe(c, t.page, r);
				end
			end
			default: ;  // unused codes leave the pool alone
		endcase
		r.free_cnt = CNT_W'(depth[c]);
		r.total    = CNT_W'(pages[c]);
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic pool_cmd_t mk_cmd(input logic [CMD_W-1:0] cmd,
			input logic [PAGE_W-1:0] page, input logic [USER_W-1:0] user,
			input logic [ESIZE_W-1:0] esize, input logic [ECOUNT_W-1:0] ecount,
			input logic [CNT_W-1:0] extra);
		return {cmd, page, user, esize, ecount, extra};
	endfunction

	// Mostly a page the plan copy holds in use, else any page
	function automatic logic [PAGE_W-1:0] pick_page();
		int unsigned p, k;
		if (pages[PLAN] != 0 && $urandom_range(0, 99) < 85) begin
			for (k = 0; k < 64; k++) begin
				p = $urandom_range(0, pages[PLAN] - 1);
				if (in_use[PLAN][p]) return PAGE_W'(p);
			end
		end
		return PAGE_W'($urandom_range(0, MAX_PAGES - 1));
	endfunction

	function automatic pool_cmd_t random_cmd();
		pool_cmd_t   t;
		int unsigned roll;
		t.page   = PAGE_W'($urandom_range(0, MAX_PAGES - 1));
		t.user   = $urandom;
		t.esize  = ($urandom_range(0, 1) != 0) ? ESIZE_W'($urandom) : ESIZE_W'($urandom_range(0, 64));
		t.ecount = ($urandom_range(0, 1) != 0) ? ECOUNT_W'($urandom)
			: ECOUNT_W'($urandom_range(0, 255));
		roll = $urandom_range(0, 99);
		if (roll < 80) t.extra = CNT_W'($urandom_range(0, 8));
		else if (roll < 95) t.extra = CNT_W'($urandom_range(0, MAX_PAGES));
		else t.extra = CNT_W'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 34) begin
			t.cmd = CMD_ALLOC;
		end else if (roll < 62) begin
			t.cmd  = CMD_FREE;
			t.page = pick_page();
		end else if (roll < 80) begin
			t.cmd  = CMD_QUERY;
			t.page = pick_page();
		end else if (roll < 92) begin
			t.cmd = CMD_EXPAND;
		end else if (roll < 96) begin
			t.cmd = CMD_INIT;
		end else begin
			t.cmd = CMD_W'($urandom_range(CMD_QUERY + 1, (1 << CMD_W) - 1));
		end
		return t;
	endfunction

	// Queue a command and advance the plan copy past it
	task automatic plan_item(input pool_cmd_t t);
		void'(pool_apply(PLAN, t));
		queued_cmds = {queued_cmds, t};
		planned++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		int c;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= PSIZE_W'(val);
		do @(posedge clk); while (!cfg_ready);
		for (c = 0; c < 2; c++) begin
			unique case (idx)
				CFG_PAGE_SIZE:    pg_size[c]    = PSIZE_W'(val);
				CFG_INITIAL:      init_pages[c] = CNT_W'(val);
				CFG_MAX_PAGES:    max_pg[c]     = CNT_W'(val);
				CFG_ALLOW_RESIZE: resize_ok[c]  = val[0];
				default: ;
			endcase
		end
	endtask

	// Write every register; valid drops only after the last transfer
	task automatic apply_settings(input int unsigned psize, input int unsigned ipages,
			input int unsigned mpages, input bit resize);
		write_reg(CFG_PAGE_SIZE, psize);
		write_reg(CFG_INITIAL, ipages);
		write_reg(CFG_MAX_PAGES, mpages);
		write_reg(CFG_ALLOW_RESIZE, resize);
		cfg_valid <= 1'b0;
		cfg_sets++;
	endtask

	// Every planned command has had its reply transfer
	task automatic wait_drained();
		do @(posedge clk);
		while (replies < planned);
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] mismatch on reply %0d: %s", $time, replies, what);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
	endtask

	// Command driver
	always @(posedge clk) begin
		bit took;
		if (arst_n) begin
			took = in_valid && in_ready;
			if (took) begin
				replies_due = {replies_due, pool_apply(LIVE, cur_cmd)};
				cmd_seen[cur_cmd.cmd]++;
				send_gap = idle_on ? $urandom_range(0, 5) : 0;
			end
			if (!in_valid || took) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (queued_cmds.size() != 0) begin
					cur_cmd = queued_cmds.pop_front();
					command       <= cur_cmd.cmd;
					page_id       <= cur_cmd.page;
					user_id       <= cur_cmd.user;
					elem_size     <= cur_cmd.esize;
					elem_count    <= cur_cmd.ecount;
					extra_pages   <= cur_cmd.extra;
					in_valid      <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Reply monitor with random back-pressure while idle_on is set
	always @(posedge clk) begin
		pool_res_t seen, want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				replies++;
				seen = {status, result_page, byte_offset, owner_id, bytes_used, stored_count,
					free_count, total_pages};
				if (replies_due.size() == 0) begin
					report_mismatch("reply with no command outstanding");
				end else begin
					want = replies_due.pop_front();
					status_seen[want.status]++;
					check_field("status", seen.status, want.status);
					check_field("result_page", seen.page, want.page);
					check_field("byte_offset", seen.offset, want.offset);
					check_field("owner_id", seen.owner, want.owner);
					check_field("bytes_used", seen.bytes, want.bytes);
					check_field("stored_count", seen.count, want.count);
					check_field("free_count", seen.free_cnt, want.free_cnt);
					check_field("total_pages", seen.total, want.total);
				end
				recv_stall = idle_on ? $urandom_range(0, 5) : 0;
			end
			if (recv_stall != 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: cycles without any transfer on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles, %0d replies pending",
					quiet, replies_due.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int p, k, n;
		pool_cmd_t t;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings, empty pool first
		plan_item(mk_cmd(CMD_ALLOC, '0, '0, '0, '0, '0));         // nothing to hand out
		plan_item(mk_cmd(CMD_FREE, '0, '0, '0, '0, '0));
		plan_item(mk_cmd(CMD_QUERY, '1, '0, '0, '0, '0));
		plan_item(mk_cmd(CMD_EXPAND, '0, '0, '0, '0, '0));        // zero pages added
		plan_item(mk_cmd(CMD_QUERY + 3'd1, '1, '1, '1, '1, '1));  // unused codes
		plan_item(mk_cmd(CMD_QUERY + 3'd2, '0, '0, '0, '0, '0));
		plan_item(mk_cmd('1, '1, '1, '1, '1, '1));
		plan_item(mk_cmd(CMD_INIT, '1, '1, '1, '1, '1));
		plan_item(mk_cmd(CMD_ALLOC, '0, '1, '1, '1, '0));         // widest descriptor
		plan_item(mk_cmd(CMD_ALLOC, '1, '0, '0, '0, '1));         // zero descriptor
		plan_item(mk_cmd(CMD_QUERY, 10'd63, '0, '0, '0, '0));
		plan_item(mk_cmd(CMD_QUERY, 10'd62, '0, '0, '0, '0));
		plan_item(mk_cmd(CMD_FREE, 10'd63, '0, '0, '0, '0));
		plan_item(mk_cmd(CMD_FREE, 10'd63, '0, '0, '0, '0));      // double free
		plan_item(mk_cmd(CMD_QUERY, 10'd63, '0, '0, '0, '0));     // query after free
		plan_item(mk_cmd(CMD_ALLOC, '0, 32'h5A5A_A5A5, 16'h00FF, 24'h000100, '0));
		plan_item(mk_cmd(CMD_EXPAND, '0, '0, '0, '0, 11'd448));   // up to the limit
		plan_item(mk_cmd(CMD_EXPAND, '0, '0, '0, '0, 11'd1));     // one past it
		plan_item(mk_cmd(CMD_FREE, 10'd62, '0, '0, '0, '0));
		wait_drained();

		// Resize off, init count above the pool size saturates
		apply_settings(1, 2047, 2047, 1'b0);
		plan_item(mk_cmd(CMD_EXPAND, '0, '0, '0, '0, 11'd1));
		plan_item(mk_cmd(CMD_INIT, '0, '0, '0, '0, '0));
		plan_item(mk_cmd(CMD_ALLOC, '0, '1, '1, '1, '0));
		plan_item(mk_cmd(CMD_QUERY, '1, '0, '0, '0, '0));
		wait_drained();

		// Page size 16777216; expand past the pool size alone
		apply_settings(16777216, 2047, 2047, 1'b1);
		plan_item(mk_cmd(CMD_QUERY, '1, '0, '0, '0, '0));
		plan_item(mk_cmd(CMD_EXPAND, '0, '0, '0, '0, 11'd1));
		plan_item(mk_cmd(CMD_FREE, '1, '0, '0, '0, '0));
		plan_item(mk_cmd(CMD_ALLOC, '0, '0, '1, '1, '0));

		// Random phases, each under its own settings
		for (p = 0; p < 7; p++) begin
			wait_drained();
			case (p)
				0: apply_settings(4096, 16, 64, 1'b1);
				1: apply_settings(16777216, 1024, 1024, 1'b1);
				2: apply_settings(1, 0, 0, 1'b1);
				3: apply_settings(16777215, $urandom_range(0, 32), $urandom_range(0, 1024), 1'b0);
				default: apply_settings($urandom_range(1, 16777216), $urandom_range(1, 32),
					$urandom_range(16, 1024), $urandom_range(0, 3) != 0);
			endcase
			idle_on = (p % 2 == 0);
			n = (p == 2) ? 40 : 125;
			t = random_cmd();
			t.cmd = CMD_INIT;
			plan_item(t);
			for (k = 1; k < n; k++) plan_item(random_cmd());
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (replies_due.size() != 0)
			report_mismatch($sformatf("%0d replies never arrived", replies_due.size()));

		$display("Covered %0d commands under %0d register settings: init %0d, allocate %0d,",
			replies, cfg_sets + 1, cmd_seen[CMD_INIT], cmd_seen[CMD_ALLOC]);
		$display("free %0d, expand %0d, query %0d, other %0d; empty %0d, bad %0d, off %0d, over %0d",
			cmd_seen[CMD_FREE], cmd_seen[CMD_EXPAND], cmd_seen[CMD_QUERY],
			cmd_seen[5] + cmd_seen[6] + cmd_seen[7], status_seen[ST_NO_FREE],
			status_seen[ST_INVALID], status_seen[ST_NO_RESIZE], status_seen[ST_EXCEEDS]);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
